/* hw/rtl/ttbd_pkg.sv */
// Shared constants and helpers for the tenths-to-BCD display digit block.
// No dependencies; used by ttbd_digit and tenths_to_bcd_display_digits_core.
package ttbd_pkg;

    localparam int NUM_DIGITS_DEF = 4;
    localparam int NUM_DIGITS_MAX = 8;

    localparam int READING_W = 16;
    localparam int BASE_W    = 4;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 8;
    localparam int IDX_W     = 3;   // digit index, wide enough for NUM_DIGITS_MAX
    localparam int POW_W     = 24;  // holds 10^7

    localparam logic [BASE_W-1:0] BASE_RESET = 4'd1;
    localparam logic [DATA_W-1:0] DP_BIT     = 8'h80;
    localparam logic [DATA_W-1:0] BLANK_CODE = 8'h0F;

    // x/10 for any 16-bit x: (x * 0xCCCD) >> 19
    localparam logic [16:0] RECIP10 = 17'd52429;
    localparam int          RECIP_SHIFT = 19;

    function automatic logic [POW_W-1:0] pow10(input logic [IDX_W-1:0] idx);
        logic [POW_W-1:0] p;
        case (idx)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            3'd7:    p = 24'd10000000;
            default: p = 24'd1;
        endcase
        return p;
    endfunction

endpackage

/* hw/rtl/ttbd_digit.sv */
// One digit step: splits the remaining value into digit and quotient and
// formats the register write. Depends on ttbd_pkg.
module ttbd_digit (
    input  logic [ttbd_pkg::READING_W-1:0] i_rest,
    input  logic [ttbd_pkg::READING_W-1:0] i_reading,
    input  logic [ttbd_pkg::IDX_W-1:0]     i_idx,
    input  logic [ttbd_pkg::BASE_W-1:0]    i_base,
    output logic [ttbd_pkg::READING_W-1:0] o_quot,
    output logic [ttbd_pkg::ADDR_W-1:0]    o_addr,
    output logic [ttbd_pkg::DATA_W-1:0]    o_data
);
    import ttbd_pkg::*;

    logic [READING_W+16:0] prod;
    logic [READING_W-1:0]  times10;
    logic [READING_W-1:0]  rem;
    logic                  blank;

    always_comb begin
        prod    = {16'd0, i_rest} * {{READING_W{1'b0}}, RECIP10};
        o_quot  = READING_W'(prod >> RECIP_SHIFT);
        times10 = (o_quot << 3) + (o_quot << 1);
        rem     = i_rest - times10;

        // leading digits from index 2 up go blank below 10^idx
        blank = (i_idx >= 3'd2) && ({{(POW_W-READING_W){1'b0}}, i_reading} < pow10(i_idx));

        if (blank) begin
            o_data = BLANK_CODE;
        end else begin
            o_data = {4'd0, rem[3:0]};
            if (i_idx == 3'd1) begin
                o_data = o_data | DP_BIT;
            end
        end

        o_addr = {1'b0, i_base} + ADDR_W'(i_idx);
    end

endmodule

/* hw/rtl/tenths_to_bcd_display_digits_core.sv */
// A single divide-by-ten step is shared by all digits of a reading; each digit enters
// the output register when it is empty or draining, and a new reading is taken as the
// last digit leaves. Throughput: one digit write per cycle while i_out_ready is high.
// Reset (synchronous, active low): pipeline empty, digit base address = 1.
// Top level: digit serializer plus output register. Depends on ttbd_pkg, ttbd_digit.
module tenths_to_bcd_display_digits_core #(
    parameter int NUM_DIGITS = ttbd_pkg::NUM_DIGITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ttbd_pkg::BASE_W-1:0]    i_cfg_digit_base_addr,

    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ttbd_pkg::READING_W-1:0] i_reading_tenths,

    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ttbd_pkg::ADDR_W-1:0]    o_reg_addr,
    output logic [ttbd_pkg::DATA_W-1:0]    o_reg_data,
    output logic                           o_last_digit
);
    import ttbd_pkg::*;

    localparam int IW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_DIGITS - 1);

    logic [BASE_W-1:0]    r_base;
    logic                 r_busy;
    logic [READING_W-1:0] r_rest;
    logic [READING_W-1:0] r_reading;
    logic [IW-1:0]        r_idx;

    logic                 r_out_valid;
    logic [ADDR_W-1:0]    r_addr;
    logic [DATA_W-1:0]    r_data;
    logic                 r_last;

    logic                 advance;
    logic                 at_last;
    logic                 accept;
    logic [READING_W-1:0] n_rest;
    logic [ADDR_W-1:0]    n_addr;
    logic [DATA_W-1:0]    n_data;

    ttbd_digit u_digit (
        .i_rest    (r_rest),
        .i_reading (r_reading),
        .i_idx     (IDX_W'(r_idx)),
        .i_base    (r_base),
        .o_quot    (n_rest),
        .o_addr    (n_addr),
        .o_data    (n_data)
    );

    // next digit moves into the output register when it is empty or draining
    assign advance     = r_busy && (!r_out_valid || i_out_ready);
    assign at_last     = (r_idx == LAST_IDX);
    assign o_in_ready  = !r_busy || (advance && at_last);
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_RESET;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_digit_base_addr;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (advance && at_last) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rest    <= i_reading_tenths;
            r_reading <= i_reading_tenths;
            r_idx     <= '0;
        end else if (advance) begin
            r_rest <= n_rest;
            r_idx  <= r_idx + IW'(1);
        end
        if (advance) begin
            r_addr <= n_addr;
            r_data <= n_data;
            r_last <= at_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_reg_addr   = r_addr;
    assign o_reg_data   = r_data;
    assign o_last_digit = r_last;

endmodule

/* tb/tb_tenths_to_bcd_display_digits_core.sv */
// Testbench for tenths_to_bcd_display_digits_core: random and directed readings, checked
// write by write against a local digit splitter. Depends on ttbd_pkg and the core RTL.
module tb_tenths_to_bcd_display_digits_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ttbd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_PAUSE = 8;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_digit_wr;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} t_rx_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [BASE_W-1:0]    cfg_base = '0;
    logic                 in_valid = 1'b0;
    logic                 o_in_ready;
    logic [READING_W-1:0] reading = '0;
    logic                 o_out_valid;
    logic                 out_ready = 1'b0;
    logic [ADDR_W-1:0]    o_reg_addr;
    logic [DATA_W-1:0]    o_reg_data;
    logic                 o_last_digit;

    logic                 in_fire = 1'b0;
    logic [BASE_W-1:0]    base_shadow = BASE_RESET;
    int                   gap_max = 0;
    bit                   hold_arm = 1'b0;
    int                   mismatches = 0;
    int                   cycles = 0;

    logic [READING_W-1:0] pending_readings[$];
    t_digit_wr            expected_writes[$];

    tenths_to_bcd_display_digits_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_digit_base_addr (cfg_base),
        .i_in_valid            (in_valid),
        .o_in_ready            (o_in_ready),
        .i_reading_tenths      (reading),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (out_ready),
        .o_reg_addr            (o_reg_addr),
        .o_reg_data            (o_reg_data),
        .o_last_digit          (o_last_digit)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Splits one reading into its digit-register writes, lowest digit first.
    function automatic void predict_display_writes(input logic [READING_W-1:0] value,
                                                   input logic [BASE_W-1:0] base);
        logic [READING_W-1:0] rest;
        logic [DATA_W-1:0]    data;
        int unsigned          limit;
        t_digit_wr            wr;
        rest  = value;
        limit = 1;
        for (int i = 0; i < NUM_DIGITS_DEF; i++) begin
            data = DATA_W'(rest % 10);
            rest = READING_W'(rest / 10);
            if (i == 1)
                data = data | DP_BIT;
            // leading zeros blank out, but only from the tens digit (index 2) up
            if (i >= 2 && value < limit)
                data = BLANK_CODE;
            wr.addr = ADDR_W'(base) + ADDR_W'(i);
            wr.data = data;
            wr.last = (i == NUM_DIGITS_DEF - 1);
            expected_writes.push_back(wr);
            limit = limit * 10;
        end
    endfunction

    function automatic logic [READING_W-1:0] pick_reading();
        int unsigned p;
        logic [READING_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = READING_W'($urandom_range(0, 99));
            1: v = READING_W'($urandom_range(100, 999));
            2: v = READING_W'($urandom_range(1000, 9999));
            3: v = READING_W'($urandom_range(10000, 65535));
            4: begin
                // around a power of ten, where blanking and wrap change
                p = 1;
                repeat ($urandom_range(1, 4)) p = p * 10;
                v = READING_W'(p - 1 + $urandom_range(0, 2));
            end
            default: v = READING_W'($urandom);
        endcase
        return v;
    endfunction

    // accept side: predict as soon as the word is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_valid && o_in_ready;
            if (in_valid && o_in_ready)
                predict_display_writes(reading, base_shadow);
        end
    end

    // sender: bursts of words with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_readings.size() > 0) begin
                in_valid <= 1'b1;
                reading  <= pending_readings.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = $urandom_range(0, gap_max);
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: switches among open, coin-flip, sparse and comb stall patterns; one long hold-off on request
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;
    int       hold_left = 0;
    bit       hold_seen = 1'b0;
    always @(negedge i_clk) begin
        rx_tick++;
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 64);
        end else begin
            rx_left--;
        end
        if (hold_arm && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= (rx_tick[1:0] != 2'd0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_digit_wr exp_wr;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected word addr=%0d data=%h last=%b",
                                          o_reg_addr, o_reg_data, o_last_digit));
            end else begin
                exp_wr = expected_writes.pop_front();
                if (o_reg_addr !== exp_wr.addr)
                    report_mismatch($sformatf("reg_addr %0d, expected %0d",
                                              o_reg_addr, exp_wr.addr));
                if (o_reg_data !== exp_wr.data)
                    report_mismatch($sformatf("reg_data %h, expected %h",
                                              o_reg_data, exp_wr.data));
                if (o_last_digit !== exp_wr.last)
                    report_mismatch($sformatf("last_digit %b, expected %b",
                                              o_last_digit, exp_wr.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d writes outstanding",
                     cycles, expected_writes.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_digit_base(input logic [BASE_W-1:0] v);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_base  <= v;
        do @(posedge i_clk); while (!(cfg_valid && o_cfg_ready));
        base_shadow = v;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_random(input int n);
        repeat (n) pending_readings.push_back(pick_reading());
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_readings.size() > 0 || in_valid || expected_writes.size() > 0);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    initial begin
        logic [READING_W-1:0] directed[$];
        directed = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd101, 16'd999,
                     16'd1000, 16'd1234, 16'd9999, 16'd10000, 16'd10009, 16'd12345,
                     16'd65535, 16'h8000, 16'h5555, 16'hAAAA, 16'd50, 16'd700};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset base, directed corners
        gap_max = 3;
        foreach (directed[k]) pending_readings.push_back(directed[k]);
        wait_idle();

        // base 0, sender never idles
        write_digit_base('0);
        gap_max = 0;
        load_random(100);
        wait_idle();

        // top base with a long receiver hold-off so the input stalls
        write_digit_base('1);
        gap_max = 0;
        hold_arm = 1'b1;
        load_random(100);
        wait_idle();

        write_digit_base(BASE_W'($urandom_range(2, 14)));
        gap_max = 6;
        load_random(100);
        wait_idle();

        write_digit_base(BASE_W'($urandom_range(0, 15)));
        gap_max = 2;
        load_random(100);
        wait_idle();

        if (expected_writes.size() != 0)
            report_mismatch($sformatf("%0d writes never arrived", expected_writes.size()));
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* tenths_to_bcd_display_digits_core.f */
hw/rtl/ttbd_pkg.sv
hw/rtl/ttbd_digit.sv
hw/rtl/tenths_to_bcd_display_digits_core.sv
tb/tb_tenths_to_bcd_display_digits_core.sv
